>>> rtl/assert_macros.svh
// Assertion helpers for the undo log RTL.
// Every check samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/mulog_pkg.sv
`default_nettype none

package mulog_pkg;

   // Log geometry
   localparam int LOG_ENTRIES = 16;
   localparam int LINE_BYTES  = 8;

   localparam int IDX_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
   localparam int CNT_W = $clog2(LOG_ENTRIES + 1);

   // Flush area layout: one address-word block header per group of lines
   localparam int ENTRIES_PER_BLOCK = (LINE_BYTES / 4 > 0) ? LINE_BYTES / 4 : 1;
   localparam int BLOCK_SHIFT       = $clog2(ENTRIES_PER_BLOCK);
   localparam int BLOCK_BYTES       = (ENTRIES_PER_BLOCK + 1) * LINE_BYTES;

   localparam logic [63:0] LINE_MASK =
      (LINE_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (LINE_BYTES * 8)) - 64'd1);

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FLUSH = 2'd1,
      OP_APPLY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_FLUSH = 2'd1,
      KIND_APPLY = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MEMORY_BASE    = 3'd0,
      CSR_UNSAFE_BASE    = 3'd1,
      CSR_UNSAFE_SIZE    = 3'd2,
      CSR_FLUSH_START    = 3'd3,
      CSR_FLUSH_BLOCKS   = 3'd4,
      CSR_FILL_THRESHOLD = 3'd5,
      CSR_FLUSH_ENABLE   = 3'd6,
      CSR_LOGGING_ENABLE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] line_address;
      logic [63:0] old_line;
   } req_type;

   typedef struct packed {
      logic [1:0]  write_kind;
      logic [31:0] target_address;
      logic [63:0] line_data;
      logic [31:0] slot_address;
      logic [31:0] logged_address;
      logic        log_empty;
      logic        overflow_flag;
      logic        at_threshold;
      logic [4:0]  free_slots;
      logic        error_code;
   } rsp_type;

   // Flush placement handed from the address calculator to the top level
   typedef struct packed {
      logic [31:0] slot_address;
      logic [31:0] target_address;
      logic        out_of_bounds;
   } flush_addr_type;

endpackage

`default_nettype wire

>>> rtl/mulog_flush_calc.sv
`default_nettype none

module mulog_flush_calc (
   input  wire logic [31:0]              memory_base,
   input  wire logic [31:0]              flush_start,
   input  wire logic [15:0]              flush_blocks,
   input  wire logic [15:0]              flushed_count,
   output mulog_pkg::flush_addr_type     flush_addr
);

   logic [15:0] blk;
   logic [15:0] off;
   logic [31:0] rel;
   logic [31:0] blk_bytes;
   logic [31:0] need_bytes;
   logic [31:0] area_bytes;

   // Split the running flush count into block number and slot within block
   assign blk = flushed_count >> mulog_pkg::BLOCK_SHIFT;
   assign off = flushed_count & 16'(mulog_pkg::ENTRIES_PER_BLOCK - 1);

   assign rel       = flush_start - memory_base;
   assign blk_bytes = 32'(blk) * 32'(mulog_pkg::BLOCK_BYTES);

   // Address word goes at the block head, line data after it
   assign flush_addr.slot_address   = rel + blk_bytes + (32'(off) << 2);
   assign flush_addr.target_address = rel + blk_bytes
                                      + (32'(off) + 32'd1) * 32'(mulog_pkg::LINE_BYTES);

   // Bound check against the whole flush area
   assign need_bytes = blk_bytes + (32'(off) + 32'd2) * 32'(mulog_pkg::LINE_BYTES);
   assign area_bytes = 32'(flush_blocks) * 32'(mulog_pkg::BLOCK_BYTES);
   assign flush_addr.out_of_bounds = need_bytes > area_bytes;

endmodule

`default_nettype wire

>>> rtl/memory_undo_log_engine_unit.sv
// Undo log beside a memory.
// Request channel (req_valid / req_stall / req_data): one transaction per
// operation: observed line write, flush tick, apply step or clear.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one
// transaction per request, in order, with write kind, addresses, line data
// and the log status after the step.
// CSR channel (csr_valid / csr_ready / csr_index / csr_data): register
// writes, always ready; write only while no request is outstanding.
// A request enters the input register when it is accepted; its response is
// then registered in the result register once that register is free.
// Throughput: one request per cycle while the response is not stalled; the limit
// is the single pass through the head/count update, from a register holding the oldest entry.
// A stalled response holds the result register; the input register then
// holds too and req_stall rises until the response is taken.
// Reset (synchronous, active high) empties the log, clears overflow and the
// flush counter and loads the register defaults. Entry storage is not
// cleared; only written entries are ever read.
`default_nettype none
`include "assert_macros.svh"

module memory_undo_log_engine_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire mulog_pkg::req_type                  req_data,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      mulog_pkg::rsp_type                  rsp_data,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [mulog_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [31:0]                         csr_data
);

   localparam int IDX_W = mulog_pkg::IDX_W;
   localparam int CNT_W = mulog_pkg::CNT_W;
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(mulog_pkg::LOG_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(mulog_pkg::LOG_ENTRIES - 1);

   // Configuration registers
   logic [31:0] memory_base_ff, unsafe_base_ff, unsafe_size_ff, flush_start_ff;
   logic [15:0] flush_blocks_ff;
   logic [4:0]  fill_threshold_ff;
   logic        flush_enable_ff, logging_enable_ff;

   // Log state
   logic [31:0]      entry_addr_ff [mulog_pkg::LOG_ENTRIES];
   logic [63:0]      entry_line_ff [mulog_pkg::LOG_ENTRIES];
   logic [31:0]      head_addr_ff;
   logic [63:0]      head_line_ff;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [15:0]      flushed_ff, flushed_in;

   // Input and result registers
   logic               stage_valid_ff;
   mulog_pkg::req_type stage_ff;
   logic               rsp_valid_ff;
   mulog_pkg::rsp_type rsp_ff, rsp_in;

   logic             out_free;
   logic             process;
   logic             entry_we;
   logic [IDX_W-1:0] entry_pos;
   logic [31:0]      entry_addr_wr;

   mulog_pkg::flush_addr_type flush_addr;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      next_idx = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
   endfunction

   mulog_flush_calc u_flush_calc (
      .memory_base   (memory_base_ff),
      .flush_start   (flush_start_ff),
      .flush_blocks  (flush_blocks_ff),
      .flushed_count (flushed_ff),
      .flush_addr    (flush_addr)
   );

   // Handshake: the input register moves when the result register frees up
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign process   = stage_valid_ff && out_free;
   assign req_stall = stage_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         memory_base_ff    <= '0;
         unsafe_base_ff    <= '0;
         unsafe_size_ff    <= '0;
         flush_start_ff    <= '0;
         flush_blocks_ff   <= '0;
         fill_threshold_ff <= 5'd16;
         flush_enable_ff   <= 1'b1;
         logging_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mulog_pkg::CSR_MEMORY_BASE:    memory_base_ff    <= csr_data;
            mulog_pkg::CSR_UNSAFE_BASE:    unsafe_base_ff    <= csr_data;
            mulog_pkg::CSR_UNSAFE_SIZE:    unsafe_size_ff    <= csr_data;
            mulog_pkg::CSR_FLUSH_START:    flush_start_ff    <= csr_data;
            mulog_pkg::CSR_FLUSH_BLOCKS:   flush_blocks_ff   <= csr_data[15:0];
            mulog_pkg::CSR_FILL_THRESHOLD: fill_threshold_ff <= csr_data[4:0];
            mulog_pkg::CSR_FLUSH_ENABLE:   flush_enable_ff   <= csr_data[0];
            mulog_pkg::CSR_LOGGING_ENABLE: logging_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Single pass over the staged transaction
   always_comb begin
      logic [31:0]      win_start;
      logic [31:0]      win_end;
      logic             in_window;
      logic [IDX_W-1:0] head;
      logic [CNT_W-1:0] cnt;
      logic [CNT_W:0]   pos_sum;
      logic             flush_ok;

      head      = oldest_ff;
      cnt       = count_ff;
      oldest_in = oldest_ff;
      count_in  = count_ff;
      overflow_in = overflow_ff;
      flushed_in  = flushed_ff;
      entry_we    = 1'b0;
      entry_pos   = '0;
      entry_addr_wr = stage_ff.line_address + memory_base_ff;
      rsp_in      = '0;

      win_start = unsafe_base_ff - memory_base_ff;
      win_end   = win_start + unsafe_size_ff;
      in_window = (stage_ff.line_address >= win_start) && (stage_ff.line_address < win_end);
      flush_ok  = flush_enable_ff && (CMP_W'(count_ff) >= CMP_W'(fill_threshold_ff))
                  && (count_ff != '0);
      pos_sum   = '0;

      case (stage_ff.operation)
         mulog_pkg::OP_WRITE: begin
            if (logging_enable_ff && !in_window) begin
               // Drop the oldest entry when full
               if (cnt == FULL_COUNT) begin
                  overflow_in = 1'b1;
                  head = next_idx(head);
                  cnt  = cnt - CNT_W'(1);
               end
               pos_sum = (CNT_W+1)'(head) + (CNT_W+1)'(cnt);
               if (pos_sum >= (CNT_W+1)'(mulog_pkg::LOG_ENTRIES)) begin
                  pos_sum = pos_sum - (CNT_W+1)'(mulog_pkg::LOG_ENTRIES);
               end
               entry_pos = IDX_W'(pos_sum);
               entry_we  = 1'b1;
               cnt       = cnt + CNT_W'(1);
            end
         end
         mulog_pkg::OP_FLUSH: begin
            if (flush_ok) begin
               rsp_in.write_kind     = mulog_pkg::KIND_FLUSH;
               rsp_in.slot_address   = flush_addr.slot_address;
               rsp_in.target_address = flush_addr.target_address;
               rsp_in.logged_address = head_addr_ff;
               rsp_in.line_data      = head_line_ff;
               rsp_in.error_code     = flush_addr.out_of_bounds;
               head       = next_idx(head);
               cnt        = cnt - CNT_W'(1);
               flushed_in = flushed_ff + 16'd1;
            end
         end
         mulog_pkg::OP_APPLY: begin
            if (cnt != '0) begin
               rsp_in.write_kind     = mulog_pkg::KIND_APPLY;
               rsp_in.logged_address = head_addr_ff;
               rsp_in.line_data      = head_line_ff;
               rsp_in.target_address = head_addr_ff - memory_base_ff;
               head = next_idx(head);
               cnt  = cnt - CNT_W'(1);
            end
            if (cnt == '0) begin
               overflow_in = 1'b0;
            end
         end
         default: begin
            // Clear: empty the log and reset the flush counter, keep overflow
            head       = '0;
            cnt        = '0;
            flushed_in = '0;
         end
      endcase

      oldest_in = head;
      count_in  = cnt;

      // Status after the step
      rsp_in.log_empty     = (cnt == '0);
      rsp_in.overflow_flag = overflow_in;
      rsp_in.at_threshold  = CMP_W'(cnt) >= CMP_W'(fill_threshold_ff);
      rsp_in.free_slots    = 5'(FULL_COUNT - cnt);
   end

   // Log state and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff      <= '0;
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         flushed_ff     <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (process) begin
            oldest_ff   <= oldest_in;
            count_ff    <= count_in;
            overflow_ff <= overflow_in;
            flushed_ff  <= flushed_in;
         end
         if (!req_stall) begin
            stage_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= process;
         end
      end
   end

   // Payload registers: capture on advance
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_ff.operation    <= req_data.operation;
         stage_ff.line_address <= req_data.line_address;
         stage_ff.old_line     <= req_data.old_line & mulog_pkg::LINE_MASK;
      end
      if (process) begin
         rsp_ff <= rsp_in;
      end
   end

   // Entry storage; keep the oldest entry registered, bypass a write into an empty log
   always_ff @(posedge clock) begin
      if (process && entry_we) begin
         entry_addr_ff[entry_pos] <= entry_addr_wr;
         entry_line_ff[entry_pos] <= stage_ff.old_line;
      end
      if (process) begin
         if (entry_we && (entry_pos == oldest_in)) begin
            head_addr_ff <= entry_addr_wr;
            head_line_ff <= stage_ff.old_line;
         end else begin
            head_addr_ff <= entry_addr_ff[oldest_in];
            head_line_ff <= entry_line_ff[oldest_in];
         end
      end
   end

   `ASSERT_CLK(a_clear_empties,
      process && (stage_ff.operation == mulog_pkg::OP_CLEAR)
      |=> (count_ff == '0) && (flushed_ff == '0) && (oldest_ff == '0),
      "clear did not empty the log")
   `ASSERT_CLK(a_apply_restores,
      process && (stage_ff.operation == mulog_pkg::OP_APPLY) && (count_ff != '0)
      |=> rsp_valid_ff && (rsp_ff.write_kind == mulog_pkg::KIND_APPLY),
      "apply on a non-empty log gave no restore write")
   `ASSERT_CLK(a_count_bound,
      rsp_valid_ff |-> (count_ff <= FULL_COUNT)
      && (rsp_ff.log_empty == (rsp_ff.free_slots == 5'(FULL_COUNT))),
      "entry count and reported status disagree")

endmodule

`default_nettype wire

>>> dv/memory_undo_log_engine_unit_test.sv
`timescale 1ns / 1ps

module memory_undo_log_engine_unit_test;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 9;
   localparam int ADDR_WORD_BYTES = 4;
   localparam int STUCK_LIMIT     = 2000;
   localparam int HOLD_CYCLES     = 120;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_OPS       = 75;
   localparam int PRESSURE_PHASE  = 3;
   localparam int DRAIN_CYCLES    = 10;
   localparam int PRINT_CAP       = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   mulog_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   mulog_pkg::rsp_type rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [mulog_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]        csr_data  = '0;

   // register copies, at their reset values
   logic [31:0] cfg_memory_base    = '0;
   logic [31:0] cfg_unsafe_base    = '0;
   logic [31:0] cfg_unsafe_size    = '0;
   logic [31:0] cfg_flush_start    = '0;
   logic [15:0] cfg_flush_blocks   = '0;
   logic [4:0]  cfg_fill_threshold = 5'd16;
   logic        cfg_flush_enable   = 1'b1;
   logic        cfg_logging_enable = 1'b0;

   // log contents as the block should hold them
   logic [31:0] logged_addrs [mulog_pkg::LOG_ENTRIES];
   logic [63:0] logged_lines [mulog_pkg::LOG_ENTRIES];
   int unsigned oldest_slot   = 0;
   int unsigned entry_total   = 0;
   logic        overflow_seen = 1'b0;
   logic [15:0] flush_total   = '0;

   mulog_pkg::req_type log_ops_to_send [$];
   mulog_pkg::rsp_type expected_log_results [$];

   logic req_idling   = 1'b1;
   logic rsp_idling   = 1'b1;
   logic hold_asked   = 1'b0;
   logic hold_taken;
   int   send_gap;
   int   stall_left;
   int   hold_left;
   int   stuck_cycles;
   int   results_seen  = 0;
   int   mismatch_count = 0;

   memory_undo_log_engine_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Advance the log by one operation and return the result it should produce
   function automatic mulog_pkg::rsp_type predict_log_step(mulog_pkg::req_type item);
      mulog_pkg::rsp_type result;
      logic [31:0]     win_start;
      logic [31:0]     win_stop;
      logic [31:0]     block_rel;
      int unsigned     blk;
      int unsigned     off;
      int unsigned     tail;
      longint unsigned span_end;
      longint unsigned area_end;
      result = '0;
      case (mulog_pkg::op_type'(item.operation))
         mulog_pkg::OP_WRITE: begin
            win_start = cfg_unsafe_base - cfg_memory_base;
            win_stop  = win_start + cfg_unsafe_size;
            if (cfg_logging_enable &&
                !(item.line_address >= win_start && item.line_address < win_stop)) begin
               // full log: drop the oldest entry to make room
               if (entry_total >= mulog_pkg::LOG_ENTRIES) begin
                  overflow_seen = 1'b1;
                  oldest_slot   = (oldest_slot + 1) % mulog_pkg::LOG_ENTRIES;
                  entry_total--;
               end
               tail = (oldest_slot + entry_total) % mulog_pkg::LOG_ENTRIES;
               logged_addrs[tail] = item.line_address + cfg_memory_base;
               logged_lines[tail] = item.old_line & mulog_pkg::LINE_MASK;
               entry_total++;
            end
         end
         mulog_pkg::OP_FLUSH: begin
            if (cfg_flush_enable && entry_total >= cfg_fill_threshold && entry_total > 0) begin
               blk       = 32'(flush_total) / mulog_pkg::ENTRIES_PER_BLOCK;
               off       = 32'(flush_total) % mulog_pkg::ENTRIES_PER_BLOCK;
               block_rel = cfg_flush_start - cfg_memory_base
                           + 32'(blk * mulog_pkg::BLOCK_BYTES);
               result.write_kind     = mulog_pkg::KIND_FLUSH;
               result.slot_address   = block_rel + 32'(off * ADDR_WORD_BYTES);
               result.target_address = block_rel + 32'((off + 1) * mulog_pkg::LINE_BYTES);
               result.logged_address = logged_addrs[oldest_slot];
               result.line_data      = logged_lines[oldest_slot];
               oldest_slot = (oldest_slot + 1) % mulog_pkg::LOG_ENTRIES;
               entry_total--;
               // flag a write that runs past the end of the flush area
               span_end = longint'(blk) * mulog_pkg::BLOCK_BYTES
                          + longint'(off + 2) * mulog_pkg::LINE_BYTES;
               area_end = longint'(mulog_pkg::BLOCK_BYTES) * longint'(cfg_flush_blocks);
               result.error_code = (span_end > area_end);
               flush_total++;
            end
         end
         mulog_pkg::OP_APPLY: begin
            if (entry_total > 0) begin
               result.write_kind     = mulog_pkg::KIND_APPLY;
               result.logged_address = logged_addrs[oldest_slot];
               result.line_data      = logged_lines[oldest_slot];
               result.target_address = logged_addrs[oldest_slot] - cfg_memory_base;
               oldest_slot = (oldest_slot + 1) % mulog_pkg::LOG_ENTRIES;
               entry_total--;
            end
            if (entry_total == 0) begin
               overflow_seen = 1'b0;
            end
         end
         mulog_pkg::OP_CLEAR: begin
            entry_total = 0;
            oldest_slot = 0;
            flush_total = '0;
         end
      endcase
      result.log_empty     = (entry_total == 0);
      result.overflow_flag = overflow_seen;
      result.at_threshold  = (entry_total >= cfg_fill_threshold);
      result.free_slots    = 5'(mulog_pkg::LOG_ENTRIES - entry_total);
      return result;
   endfunction

   function automatic void queue_log_op(mulog_pkg::op_type op, logic [31:0] addr,
                                        logic [63:0] line);
      mulog_pkg::req_type item;
      item.operation    = op;
      item.line_address = addr;
      item.old_line     = line;
      log_ops_to_send.insert(log_ops_to_send.size(), item);
   endfunction

   task automatic report_mismatch(string what);
      if (mismatch_count < PRINT_CAP) begin
         $display("ERROR result %0d: %s", results_seen, what);
      end
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   // Write one register; the block is idle whenever this is called
   task automatic write_csr(mulog_pkg::csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mulog_pkg::CSR_MEMORY_BASE:    cfg_memory_base    = value;
         mulog_pkg::CSR_UNSAFE_BASE:    cfg_unsafe_base    = value;
         mulog_pkg::CSR_UNSAFE_SIZE:    cfg_unsafe_size    = value;
         mulog_pkg::CSR_FLUSH_START:    cfg_flush_start    = value;
         mulog_pkg::CSR_FLUSH_BLOCKS:   cfg_flush_blocks   = value[15:0];
         mulog_pkg::CSR_FILL_THRESHOLD: cfg_fill_threshold = value[4:0];
         mulog_pkg::CSR_FLUSH_ENABLE:   cfg_flush_enable   = value[0];
         mulog_pkg::CSR_LOGGING_ENABLE: cfg_logging_enable = value[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (log_ops_to_send.size() != 0 || req_valid || expected_log_results.size() != 0);
   endtask

   // Sender: present queued operations, with random gaps between them while req_idling is set
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_log_results.insert(expected_log_results.size(),
                                        predict_log_step(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (log_ops_to_send.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= log_ops_to_send[0];
               log_ops_to_send.delete(0);
               if (req_idling && $urandom_range(0, 7) == 0) begin
                  send_gap <= $urandom_range(1, 19);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall bursts while rsp_idling is set, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asked && !hold_taken) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_idling && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result against the oldest prediction
   always @(posedge clock) begin : check_results
      mulog_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_log_results.size() == 0) begin
            report_mismatch("result with no operation outstanding");
         end else begin
            want = expected_log_results[0];
            expected_log_results.delete(0);
            check_field("write_kind", 64'(rsp_data.write_kind), 64'(want.write_kind));
            check_field("target_address", 64'(rsp_data.target_address),
                        64'(want.target_address));
            check_field("line_data", rsp_data.line_data, want.line_data);
            check_field("slot_address", 64'(rsp_data.slot_address), 64'(want.slot_address));
            check_field("logged_address", 64'(rsp_data.logged_address),
                        64'(want.logged_address));
            check_field("log_empty", 64'(rsp_data.log_empty), 64'(want.log_empty));
            check_field("overflow_flag", 64'(rsp_data.overflow_flag),
                        64'(want.overflow_flag));
            check_field("at_threshold", 64'(rsp_data.at_threshold), 64'(want.at_threshold));
            check_field("free_slots", 64'(rsp_data.free_slots), 64'(want.free_slots));
            check_field("error_code", 64'(rsp_data.error_code), 64'(want.error_code));
         end
         results_seen++;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [31:0] cfg_values [8];
      logic [31:0] win_start;
      logic [31:0] win_stop;
      logic [31:0] addr;
      int          phase;
      int          made;
      int          run_len;
      int          i;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: logging off, so a write leaves the log empty
      queue_log_op(mulog_pkg::OP_WRITE, 32'h0000_0000, 64'h0);
      wait_drained();

      // small window at 0x1000..0x103f, one-block flush area, threshold of two
      cfg_values[mulog_pkg::CSR_MEMORY_BASE]    = 32'h8000_0000;
      cfg_values[mulog_pkg::CSR_UNSAFE_BASE]    = 32'h8000_1000;
      cfg_values[mulog_pkg::CSR_UNSAFE_SIZE]    = 32'h0000_0040;
      cfg_values[mulog_pkg::CSR_FLUSH_START]    = 32'h8001_0000;
      cfg_values[mulog_pkg::CSR_FLUSH_BLOCKS]   = 32'd1;
      cfg_values[mulog_pkg::CSR_FILL_THRESHOLD] = 32'd2;
      cfg_values[mulog_pkg::CSR_FLUSH_ENABLE]   = 32'd1;
      cfg_values[mulog_pkg::CSR_LOGGING_ENABLE] = 32'd1;
      for (i = 0; i < 8; i++) write_csr(mulog_pkg::csr_index_type'(i), cfg_values[i]);
      @(negedge clock);
      // window start is skipped, the edges around it and misaligned writes are kept
      queue_log_op(mulog_pkg::OP_WRITE, 32'h0000_1000, 64'h0);
      queue_log_op(mulog_pkg::OP_WRITE, 32'h0000_0FFF, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_log_op(mulog_pkg::OP_WRITE, 32'h0000_1040, 64'h0123_4567_89AB_CDEF);
      queue_log_op(mulog_pkg::OP_WRITE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_log_op(mulog_pkg::OP_WRITE, 32'h0000_0000, 64'h0);
      // fill past capacity so the oldest entry drops out
      for (i = 0; i < 13; i++) begin
         queue_log_op(mulog_pkg::OP_WRITE, 32'h2000 + 32'(i * 8),
                      i[0] ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA);
      end
      // two flushes fit the area, the third runs past it
      queue_log_op(mulog_pkg::OP_FLUSH, 32'h0, 64'h0);
      queue_log_op(mulog_pkg::OP_FLUSH, 32'h0, 64'h0);
      queue_log_op(mulog_pkg::OP_FLUSH, 32'h0, 64'h0);
      queue_log_op(mulog_pkg::OP_APPLY, 32'h0, 64'h0);
      // clear keeps overflow, an apply on the empty log drops it
      queue_log_op(mulog_pkg::OP_CLEAR, 32'h0, 64'h0);
      queue_log_op(mulog_pkg::OP_APPLY, 32'h0, 64'h0);
      wait_drained();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_idling = (phase % 3 != 2) && (phase != RANDOM_PHASES - 1);
         rsp_idling = (phase % 4 != 1) && (phase != RANDOM_PHASES - 1);
         if (phase == 0) begin
            // all registers low: empty window, flush whenever anything is logged
            foreach (cfg_values[i]) cfg_values[i] = 32'h0;
            cfg_values[mulog_pkg::CSR_FLUSH_ENABLE]   = 32'd1;
            cfg_values[mulog_pkg::CSR_LOGGING_ENABLE] = 32'd1;
         end else if (phase == 1) begin
            // registers high: wrapped window, flush only once full
            cfg_values[mulog_pkg::CSR_MEMORY_BASE]    = 32'hFFFF_FFFF;
            cfg_values[mulog_pkg::CSR_UNSAFE_BASE]    = 32'h0000_000F;
            cfg_values[mulog_pkg::CSR_UNSAFE_SIZE]    = 32'hFFFF_FFFF;
            cfg_values[mulog_pkg::CSR_FLUSH_START]    = 32'hFFFF_FFFF;
            cfg_values[mulog_pkg::CSR_FLUSH_BLOCKS]   = 32'd65535;
            cfg_values[mulog_pkg::CSR_FILL_THRESHOLD] = 32'd16;
            cfg_values[mulog_pkg::CSR_FLUSH_ENABLE]   = 32'd1;
            cfg_values[mulog_pkg::CSR_LOGGING_ENABLE] = 32'd1;
         end else begin
            cfg_values[mulog_pkg::CSR_MEMORY_BASE]    = $urandom;
            cfg_values[mulog_pkg::CSR_UNSAFE_BASE]    = cfg_values[mulog_pkg::CSR_MEMORY_BASE] +
                                                        $urandom_range(0, 32'h2000);
            cfg_values[mulog_pkg::CSR_UNSAFE_SIZE]    = ($urandom_range(0, 3) == 0) ? $urandom :
                                                        $urandom_range(0, 32'h1000);
            cfg_values[mulog_pkg::CSR_FLUSH_START]    = $urandom;
            cfg_values[mulog_pkg::CSR_FLUSH_BLOCKS]   = ($urandom_range(0, 3) == 0) ?
                                                        $urandom_range(0, 65535) :
                                                        $urandom_range(0, 12);
            cfg_values[mulog_pkg::CSR_FILL_THRESHOLD] = $urandom_range(0, 16);
            cfg_values[mulog_pkg::CSR_FLUSH_ENABLE]   = 32'($urandom_range(0, 4) != 0);
            cfg_values[mulog_pkg::CSR_LOGGING_ENABLE] = 32'($urandom_range(0, 5) != 0);
         end
         for (i = 0; i < 8; i++) write_csr(mulog_pkg::csr_index_type'(i), cfg_values[i]);
         @(negedge clock);

         win_start = cfg_unsafe_base - cfg_memory_base;
         win_stop  = win_start + cfg_unsafe_size;
         made = 0;
         while (made < PHASE_OPS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  // run of line writes, around and inside the unlogged window
                  run_len = $urandom_range(1, 20);
                  for (i = 0; i < run_len; i++) begin
                     case ($urandom_range(0, 6))
                        0:       addr = $urandom;
                        1:       addr = win_start - 32'd1;
                        2:       addr = win_start;
                        3:       addr = win_stop - 32'd1;
                        4:       addr = win_stop;
                        default: addr = 32'($urandom_range(0, 32'h3FF)) << 3;
                     endcase
                     queue_log_op(mulog_pkg::OP_WRITE, addr, {$urandom, $urandom});
                  end
                  made += run_len;
               end
               4, 5: begin
                  run_len = $urandom_range(1, 8);
                  for (i = 0; i < run_len; i++) begin
                     queue_log_op(mulog_pkg::OP_FLUSH, $urandom, {$urandom, $urandom});
                  end
                  made += run_len;
               end
               6, 7: begin
                  run_len = $urandom_range(1, 8);
                  for (i = 0; i < run_len; i++) begin
                     queue_log_op(mulog_pkg::OP_APPLY, $urandom, {$urandom, $urandom});
                  end
                  made += run_len;
               end
               8: begin
                  queue_log_op(mulog_pkg::OP_CLEAR, $urandom, {$urandom, $urandom});
                  made++;
               end
               default: begin
                  queue_log_op(mulog_pkg::op_type'($urandom_range(0, 3)), $urandom,
                               {$urandom, $urandom});
                  made++;
               end
            endcase
         end
         // hold the result side while the sender keeps offering
         if (phase == PRESSURE_PHASE) begin
            hold_asked = 1'b1;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
